FILE: rtl/gfr_pkg.sv
// Package for the GF(2) matrix rank unit: sizes, beat types, column mask helper.
// No dependencies.
package gfr_pkg;

  localparam int MaxSize = 32;                  // largest matrix held
  localparam int RowW    = 32;                  // bits in one row beat
  localparam int CfgW    = 6;                   // width of matrix_size
  localparam int RankW   = 6;                   // width of rank
  localparam int IdxW    = $clog2(MaxSize);     // row / column index
  localparam int CntW    = $clog2(MaxSize + 1); // row count, 0..MaxSize

  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            last_row;
  } gfr_in_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             overflow;
  } gfr_out_t;

  // Ones in columns below n.
  function automatic logic [RowW-1:0] col_mask(logic [CntW-1:0] n);
    logic [RowW-1:0] m;
    for (int k = 0; k < RowW; k++) begin
      m[k] = (32'(k) < 32'(n));
    end
    return m;
  endfunction

endpackage

FILE: rtl/gf2_matrix_rank_unit.sv
// GF(2) matrix rank unit: row store, basis table and the column-step sequencer.
// Depends on gfr_pkg.
//
//  port group       dir  handshake                  beat
//  start/in_i       in   start && !busy             one row (row_bits, last_row)
//  res_o            out  res_valid_o, 1-cycle pulse rank, overflow
//  cfg_data_i       in   cfg_valid_i && cfg_ready_o matrix_size
//
// Rows may come back to back.
// The last row starts the reduction: each of the k = min(rows loaded, size)
// rows is fetched and swept across the columns by one shared XOR step per
// cycle up to its pivot or the last column; the result cycle follows the
// last row's sweep. busy is high from the last row until the result cycle
// ends; cfg_ready_o is low while busy or start is high. The receiver cannot
// stall. No clearing pass after reset.
module gf2_matrix_rank_unit
  import gfr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  gfr_in_t         in_i,
  output logic            res_valid_o,
  output gfr_out_t        res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StFetch  = 2'd1;
  localparam logic [1:0] StReduce = 2'd2;
  localparam logic [1:0] StDone   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CfgW-1:0]    size_q;
  logic [CntW-1:0]    n_eff;
  logic [RowW-1:0]    mask;
  logic [IdxW-1:0]    last_col;

  logic [RowW-1:0]    rows_q  [MaxSize];
  logic [RowW-1:0]    basis_q [MaxSize];
  logic [MaxSize-1:0] bvalid_q;

  logic [CntW-1:0]    loaded_q, loaded_d;
  logic               ovf_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    row_q;
  logic [IdxW-1:0]    col_q;
  logic [RowW-1:0]    vec_q;
  logic [RankW-1:0]   rank_q;

  logic               accept;
  logic               store_row;
  logic               piv_bit;
  logic               new_pivot;
  logic               row_end;

  // effective size: 0 acts as 1, above MaxSize acts as MaxSize
  always_comb begin
    if (size_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(size_q) > 32'(MaxSize)) begin
      n_eff = CntW'(MaxSize);
    end else begin
      n_eff = CntW'(size_q);
    end
  end

  assign mask     = col_mask(n_eff);
  assign last_col = IdxW'(n_eff - CntW'(1));

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  // size may not move under a reduction or a row beat
  assign cfg_ready_o = !busy && !start;
  assign store_row   = accept && (loaded_q < n_eff);
  assign loaded_d    = store_row ? loaded_q + CntW'(1) : loaded_q;

  assign piv_bit   = vec_q[col_q];
  assign new_pivot = (state_q == StReduce) && piv_bit && !bvalid_q[col_q];
  assign row_end   = new_pivot || (col_q == last_col);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && in_i.last_row) begin
          state_d = StFetch;
          if (loaded_d == '0) begin
            state_d = StDone;
          end
        end
      end
      StFetch: begin
        state_d = StReduce;
      end
      StReduce: begin
        if (row_end) begin
          state_d = (row_q + CntW'(1) == count_q) ? StDone : StFetch;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      size_q   <= CfgW'(MaxSize);
      loaded_q <= '0;
      ovf_q    <= 1'b0;
      bvalid_q <= '0;
      count_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      rank_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
      if (state_q == StDone) begin
        loaded_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        loaded_q <= loaded_d;
        if (accept && !store_row) begin
          ovf_q <= 1'b1;
        end
      end
      if (accept && in_i.last_row) begin
        bvalid_q <= '0;
        rank_q   <= '0;
        row_q    <= '0;
        count_q  <= (loaded_d < n_eff) ? loaded_d : n_eff;
      end
      if (state_q == StFetch) begin
        col_q <= '0;
      end
      if (state_q == StReduce) begin
        if (new_pivot) begin
          bvalid_q[col_q] <= 1'b1;
          rank_q          <= rank_q + RankW'(1);
        end
        if (row_end) begin
          row_q <= row_q + CntW'(1);
        end else begin
          col_q <= col_q + IdxW'(1);
        end
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (store_row) begin
      rows_q[loaded_q[IdxW-1:0]] <= in_i.row_bits & mask;
    end
    if (state_q == StFetch) begin
      vec_q <= rows_q[row_q[IdxW-1:0]] & mask;
    end
    if (state_q == StReduce) begin
      if (new_pivot) begin
        basis_q[col_q] <= vec_q;
      end else if (piv_bit) begin
        // basis row at this column has its lowest one here
        vec_q <= vec_q ^ basis_q[col_q];
      end
    end
  end

  assign res_valid_o    = (state_q == StDone);
  assign res_o.rank     = rank_q;
  assign res_o.overflow = ovf_q;

`ifndef SYNTHESIS
  a_rank_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (32'(res_o.rank) <= 32'(n_eff)))
    else $error("rank exceeds matrix size");

  a_row_beat_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.last_row) |=> !busy)
    else $error("plain row beat left unit busy");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!busy && loaded_q == '0 && !ovf_q))
    else $error("load state not cleared after result");

  a_loaded_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(loaded_q) <= 32'(MaxSize)))
    else $error("row count beyond storage");
`endif

endmodule
